// File: rtl/dccb_pkg.sv
`timescale 1ns / 1ps
package dccb_pkg;

  // Screen and queue geometry
  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 180;
  localparam int QUEUE_DEPTH   = 128;

  localparam int PIX_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ROW_BITS  = 32;
  localparam int BIT_W     = $clog2(ROW_BITS);
  localparam int ROW_COUNT = (PIX_COUNT + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_W     = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int IDX_W     = ROW_W + BIT_W;
  localparam int QPTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int CHG_W     = $clog2(PIX_COUNT + 1);

  // Field widths
  localparam int OP_W   = 2;
  localparam int OPC_W  = 5;
  localparam int FLD_W  = 12;
  localparam int FE_W   = 11;
  localparam int WORD_W = 64;
  localparam int PAY_W  = 35;
  localparam int KIND_W = 2;

  // Reciprocal for pixel index / SCREEN_HEIGHT
  localparam int DIV_SHIFT = IDX_W + $clog2(SCREEN_HEIGHT) + 1;
  localparam int RECIP_W   = DIV_SHIFT + 1;
  localparam longint unsigned RECIP =
    ((64'd1 << DIV_SHIFT) + SCREEN_HEIGHT - 1) / SCREEN_HEIGHT;

  // Operation codes
  localparam logic [OP_W-1:0] OP_DRAW  = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_DRAIN = 2'd2;

  // Opcodes
  localparam logic [OPC_W-1:0] PIXEL_OPCODE = 5'd3;
  localparam logic [OPC_W-1:0] CLEAR_OPCODE = 5'd2;
  localparam logic [WORD_W-1:0] CLEAR_WORD  = {CLEAR_OPCODE, {(WORD_W-OPC_W){1'b0}}};

  // Word kinds
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUEUE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic              capture;
    logic              clr_start;
    logic              clr_step;
    logic              q_push;
    logic              set_ovf;
    logic              q_pop;
    logic              emit_clear;
    logic              pix_rd;
    logic              pix_wr;
    logic              scan_init;
    logic              scan_rd;
    logic              scan_chk;
    logic              div1;
    logic              div2;
    logic              out_load;
    logic              set_kind;
    logic [KIND_W-1:0] kind;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            is_pixel;
    logic            in_range;
    logic            word_zero;
    logic            q_full;
    logic            q_empty;
    logic            clear_pending;
    logic            total_zero;
    logic            clr_last;
    logic            found;
  } dp_stat_t;

endpackage

// File: rtl/draw_command_coalescing_buffer.sv
`timescale 1ns / 1ps
// Draw, clear-screen and drain commands are taken one at a time while busy_o is low.
// Draw: S_DECODE pushes a queued command; a pixel write adds a bitmap and payload RMW.
// Clear: one cycle per bitmap row, ROW_COUNT rows (1800 at 320x180).
// Drain: clear/queue/empty words pass S_DECODE and S_OUT before done_o pulses; a changed
// pixel adds S_SC_RD, S_SC_CHK per 32-pixel row scanned, then S_SC_DIV1 and S_SC_DIV2.
// Results cannot be stalled. After reset the bitmap is cleared row by row with busy_o high.
module draw_command_coalescing_buffer import dccb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [OP_W-1:0]   operation_i,
  input  logic [OPC_W-1:0]  opcode_i,
  input  logic [FLD_W-1:0]  field_x_i,
  input  logic [FLD_W-1:0]  field_y_i,
  input  logic [FLD_W-1:0]  field_c_i,
  input  logic [FLD_W-1:0]  field_d_i,
  input  logic [FE_W-1:0]   field_e_i,
  output logic              done_o,
  output logic [WORD_W-1:0] command_word_o,
  output logic [KIND_W-1:0] word_kind_o,
  output logic              last_o,
  output logic              overflow_seen_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     busy;

  // Controller
  dccb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i && !busy),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // Datapath
  dccb_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .operation_i     (operation_i),
    .opcode_i        (opcode_i),
    .field_x_i       (field_x_i),
    .field_y_i       (field_y_i),
    .field_c_i       (field_c_i),
    .field_d_i       (field_d_i),
    .field_e_i       (field_e_i),
    .command_word_o  (command_word_o),
    .word_kind_o     (word_kind_o),
    .last_o          (last_o),
    .overflow_seen_o (overflow_seen_o),
    .done_o          (done_o)
  );

  assign busy_o = busy;

endmodule

// File: rtl/dccb_ctrl.sv
`timescale 1ns / 1ps
module dccb_ctrl import dccb_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  dp_stat_t        stat_i,
  output dp_cmd_t         cmd_o,
  output logic            busy_o
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DECODE, S_PW_RD, S_PW_WR,
    S_SC_RD, S_SC_CHK, S_SC_DIV1, S_SC_DIV2, S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  // Decode next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.kind = KIND_NONE;
    case (state_q)
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_IDLE;
        case (stat_i.op)
          OP_DRAW: begin
            if (stat_i.is_pixel) begin
              if (stat_i.in_range) state_d = S_PW_RD;
            end else if (!stat_i.word_zero) begin
              if (stat_i.q_full) cmd_o.set_ovf = 1'b1;
              else cmd_o.q_push = 1'b1;
            end
          end
          OP_CLEAR: begin
            cmd_o.clr_start = 1'b1;
            state_d = S_CLR;
          end
          OP_DRAIN: begin
            cmd_o.set_kind = 1'b1;
            if (stat_i.clear_pending) begin
              cmd_o.emit_clear = 1'b1;
              cmd_o.kind = KIND_CLEAR;
              state_d = S_OUT;
            end else if (!stat_i.q_empty) begin
              cmd_o.q_pop = 1'b1;
              cmd_o.kind = KIND_QUEUE;
              state_d = S_OUT;
            end else if (!stat_i.total_zero) begin
              cmd_o.scan_init = 1'b1;
              cmd_o.kind = KIND_PIXEL;
              state_d = S_SC_RD;
            end else begin
              cmd_o.kind = KIND_NONE;
              state_d = S_OUT;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_PW_RD: begin
        cmd_o.pix_rd = 1'b1;
        state_d = S_PW_WR;
      end
      S_PW_WR: begin
        cmd_o.pix_wr = 1'b1;
        state_d = S_IDLE;
      end
      S_SC_RD: begin
        cmd_o.scan_rd = 1'b1;
        state_d = S_SC_CHK;
      end
      S_SC_CHK: begin
        cmd_o.scan_chk = 1'b1;
        state_d = stat_i.found ? S_SC_DIV1 : S_SC_RD;
      end
      S_SC_DIV1: begin
        cmd_o.div1 = 1'b1;
        state_d = S_SC_DIV2;
      end
      S_SC_DIV2: begin
        cmd_o.div2 = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        cmd_o.out_load = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state and busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      busy_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != S_IDLE);
    end
  end

  assign busy_o = busy_q;

endmodule

// File: rtl/dccb_datapath.sv
`timescale 1ns / 1ps
module dccb_datapath import dccb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  output dp_stat_t          stat_o,
  input  logic [OP_W-1:0]   operation_i,
  input  logic [OPC_W-1:0]  opcode_i,
  input  logic [FLD_W-1:0]  field_x_i,
  input  logic [FLD_W-1:0]  field_y_i,
  input  logic [FLD_W-1:0]  field_c_i,
  input  logic [FLD_W-1:0]  field_d_i,
  input  logic [FE_W-1:0]   field_e_i,
  output logic [WORD_W-1:0] command_word_o,
  output logic [KIND_W-1:0] word_kind_o,
  output logic              last_o,
  output logic              overflow_seen_o,
  output logic              done_o
);

  // Memories
  logic [2*ROW_BITS-1:0] bmap_mem [ROW_COUNT];
  logic [PAY_W-1:0]      pay_mem  [PIX_COUNT];
  logic [WORD_W-1:0]     q_mem    [QUEUE_DEPTH];
  logic [2*ROW_BITS-1:0] bmap_rd_q;
  logic [PAY_W-1:0]      pay_rd_q;
  logic [WORD_W-1:0]     q_rd_q;

  // Captured transaction
  logic [OP_W-1:0]   op_q;
  logic [WORD_W-1:0] word_q;
  logic [IDX_W-1:0]  idx_q;
  logic              in_range_q;

  // Control state
  logic [QPTR_W-1:0] head_q;
  logic [QCNT_W-1:0] count_q;
  logic              cp_q;
  logic              ovf_q;
  logic [CHG_W-1:0]  total_q;
  logic [IDX_W-1:0]  scan_q;
  logic [ROW_W-1:0]  clr_row_q;
  logic [ROW_W-1:0]  scan_row_q;
  logic              first_q;
  logic [KIND_W-1:0] kind_q;
  logic              done_q;

  // Scan result and coordinates
  logic [IDX_W-1:0]  found_idx_q;
  logic [FLD_W-1:0]  x_q;
  logic [FLD_W-1:0]  y_q;

  // Output registers
  logic [WORD_W-1:0] word_out_q;
  logic [KIND_W-1:0] kind_out_q;
  logic              last_q;
  logic              ovf_out_q;

  logic [PAY_W-1:0]      payload;
  logic [2*FLD_W-1:0]    idx_prod;
  logic [BIT_W-1:0]      pw_bit;
  logic                  pw_same;
  logic [2*ROW_BITS-1:0] pw_row;
  logic [ROW_BITS-1:0]   scan_mask;
  logic [ROW_BITS-1:0]   scan_hits;
  logic [BIT_W-1:0]      hit_bit;
  logic [IDX_W-1:0]      hit_idx;
  logic [2*ROW_BITS-1:0] sc_row;
  logic [QPTR_W:0]       tail_sum;
  logic [QPTR_W-1:0]     tail;
  logic [IDX_W+RECIP_W-1:0] div_prod;
  logic [IDX_W-1:0]      xh;

  assign payload  = word_q[PAY_W-1:0];
  assign idx_prod = field_x_i * FLD_W'(SCREEN_HEIGHT) + (2*FLD_W)'(field_y_i);

  // Pixel write merge
  always_comb begin
    pw_bit  = idx_q[BIT_W-1:0];
    pw_same = bmap_rd_q[pw_bit] && (pay_rd_q == payload);
    pw_row  = bmap_rd_q;
    pw_row[pw_bit] = 1'b1;
    pw_row[ROW_BITS + pw_bit] = 1'b1;
  end

  // Find first changed pixel in the row at or after the scan point
  always_comb begin
    scan_mask = first_q ? ~((ROW_BITS'(1) << scan_q[BIT_W-1:0]) - ROW_BITS'(1))
                        : '1;
    scan_hits = bmap_rd_q[2*ROW_BITS-1:ROW_BITS] & scan_mask;
    hit_bit   = '0;
    for (int i = ROW_BITS - 1; i >= 0; i--) begin
      if (scan_hits[i]) hit_bit = BIT_W'(i);
    end
    hit_idx = {scan_row_q, hit_bit};
    sc_row  = bmap_rd_q;
    sc_row[ROW_BITS + hit_bit] = 1'b0;
  end

  // Queue tail address
  always_comb begin
    tail_sum = {1'b0, head_q} + (QPTR_W+1)'(count_q);
    if (tail_sum >= (QPTR_W+1)'(QUEUE_DEPTH)) tail_sum = tail_sum - (QPTR_W+1)'(QUEUE_DEPTH);
    tail = tail_sum[QPTR_W-1:0];
  end

  assign div_prod = found_idx_q * (IDX_W+RECIP_W)'(RECIP);
  assign xh       = IDX_W'(x_q * IDX_W'(SCREEN_HEIGHT));

  // Bitmap memory: clear pass, pixel merge, scan retire
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      bmap_mem[clr_row_q] <= '0;
    end else if (cmd_i.pix_wr && !pw_same) begin
      bmap_mem[idx_q[IDX_W-1:BIT_W]] <= pw_row;
    end else if (cmd_i.scan_chk && (scan_hits != '0)) begin
      bmap_mem[scan_row_q] <= sc_row;
    end
    if (cmd_i.pix_rd) begin
      bmap_rd_q <= bmap_mem[idx_q[IDX_W-1:BIT_W]];
    end else if (cmd_i.scan_rd) begin
      bmap_rd_q <= bmap_mem[scan_row_q];
    end
  end

  // Payload memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_wr && !pw_same) pay_mem[idx_q] <= payload;
    if (cmd_i.pix_rd) begin
      pay_rd_q <= pay_mem[idx_q];
    end else if (cmd_i.scan_chk && (scan_hits != '0)) begin
      pay_rd_q <= pay_mem[hit_idx];
    end
  end

  // Command queue memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.q_push) q_mem[tail] <= word_q;
    if (cmd_i.q_pop) q_rd_q <= q_mem[head_q];
  end

  // Capture transaction and compute pixel address
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      word_q     <= {opcode_i, field_x_i, field_y_i, field_c_i, field_d_i, field_e_i};
      idx_q      <= IDX_W'(idx_prod);
      in_range_q <= (field_x_i < FLD_W'(SCREEN_WIDTH)) && (field_y_i < FLD_W'(SCREEN_HEIGHT));
    end
    if (cmd_i.scan_chk) found_idx_q <= hit_idx;
    if (cmd_i.div1) x_q <= FLD_W'(div_prod >> DIV_SHIFT);
    if (cmd_i.div2) y_q <= FLD_W'(found_idx_q - xh);
    if (cmd_i.out_load) begin
      case (kind_q)
        KIND_CLEAR: word_out_q <= CLEAR_WORD;
        KIND_QUEUE: word_out_q <= q_rd_q;
        KIND_PIXEL: word_out_q <= {PIXEL_OPCODE, x_q, y_q, pay_rd_q};
        default:    word_out_q <= '0;
      endcase
      kind_out_q <= kind_q;
      last_q     <= !cp_q && (count_q == '0) && (total_q == '0);
      ovf_out_q  <= ovf_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q       <= OP_DRAW;
      head_q     <= '0;
      count_q    <= '0;
      cp_q       <= 1'b0;
      ovf_q      <= 1'b0;
      total_q    <= '0;
      scan_q     <= '0;
      clr_row_q  <= '0;
      scan_row_q <= '0;
      first_q    <= 1'b0;
      kind_q     <= KIND_NONE;
      done_q     <= 1'b0;
    end else begin
      done_q <= cmd_i.out_load;
      if (cmd_i.capture) op_q <= operation_i;
      if (cmd_i.set_kind) kind_q <= cmd_i.kind;
      if (cmd_i.set_ovf) ovf_q <= 1'b1;
      if (cmd_i.q_push) count_q <= count_q + QCNT_W'(1);
      if (cmd_i.q_pop) begin
        count_q <= count_q - QCNT_W'(1);
        head_q  <= (head_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + QPTR_W'(1);
      end
      if (cmd_i.emit_clear) cp_q <= 1'b0;
      // start a clear pass
      if (cmd_i.clr_start) begin
        cp_q      <= 1'b1;
        total_q   <= '0;
        scan_q    <= '0;
        clr_row_q <= '0;
      end
      if (cmd_i.clr_step) clr_row_q <= clr_row_q + ROW_W'(1);
      // count newly changed pixels
      if (cmd_i.pix_wr && !pw_same && !bmap_rd_q[ROW_BITS + pw_bit]) begin
        total_q <= total_q + CHG_W'(1);
      end
      if (cmd_i.scan_init) begin
        scan_row_q <= scan_q[IDX_W-1:BIT_W];
        first_q    <= 1'b1;
      end
      // advance scan, retire hit
      if (cmd_i.scan_chk) begin
        if (scan_hits != '0) begin
          total_q <= total_q - CHG_W'(1);
          scan_q  <= (hit_idx == IDX_W'(PIX_COUNT - 1)) ? '0 : hit_idx + IDX_W'(1);
        end else begin
          first_q    <= 1'b0;
          scan_row_q <= (scan_row_q == ROW_W'(ROW_COUNT - 1)) ? '0 : scan_row_q + ROW_W'(1);
        end
      end
    end
  end

  // Status
  always_comb begin
    stat_o.op            = op_q;
    stat_o.is_pixel      = (word_q[WORD_W-1:WORD_W-OPC_W] == PIXEL_OPCODE);
    stat_o.in_range      = in_range_q;
    stat_o.word_zero     = (word_q == '0);
    stat_o.q_full        = (count_q == QCNT_W'(QUEUE_DEPTH));
    stat_o.q_empty       = (count_q == '0);
    stat_o.clear_pending = cp_q;
    stat_o.total_zero    = (total_q == '0);
    stat_o.clr_last      = (clr_row_q == ROW_W'(ROW_COUNT - 1));
    stat_o.found         = (scan_hits != '0);
  end

  assign command_word_o  = word_out_q;
  assign word_kind_o     = kind_out_q;
  assign last_o          = last_q;
  assign overflow_seen_o = ovf_out_q;
  assign done_o          = done_q;

endmodule

// File: rtl/dccb_checker.sv
`timescale 1ns / 1ps
module dccb_checker import dccb_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              busy_o,
  input logic              done_o,
  input logic [WORD_W-1:0] command_word_o,
  input logic [KIND_W-1:0] word_kind_o,
  input logic              last_o
);

  // An empty drain carries a zero word and marks the end
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (word_kind_o == KIND_NONE) |-> (command_word_o == '0) && last_o)
    else $error("empty drain word malformed");

  // A clear transaction carries the clear word
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (word_kind_o == KIND_CLEAR) |-> (command_word_o == CLEAR_WORD))
    else $error("clear word malformed");

  // A changed pixel carries the pixel opcode and an on-screen coordinate
  a_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (word_kind_o == KIND_PIXEL) |->
      (command_word_o[WORD_W-1:WORD_W-OPC_W] == PIXEL_OPCODE) &&
      (command_word_o[58:47] < FLD_W'(SCREEN_WIDTH)) &&
      (command_word_o[46:35] < FLD_W'(SCREEN_HEIGHT)))
    else $error("pixel word malformed");

  // A result only follows a cycle of work
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result without preceding work");

  // Strobe lasts one cycle
  a_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

endmodule

bind draw_command_coalescing_buffer dccb_checker u_dccb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .busy_o         (busy_o),
  .done_o         (done_o),
  .command_word_o (command_word_o),
  .word_kind_o    (word_kind_o),
  .last_o         (last_o)
);
